/* sv/i2cbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Request and result payload types, request codes and queue sizing shared by
// the front end, the request queue, the sequencer and the top level.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    // Request codes as carried in req_type.
    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_SACK  = 3'd4;
    localparam logic [2:0] REQ_CACK  = 3'd5;
    localparam logic [2:0] REQ_TICK  = 3'd6;
    localparam logic [2:0] REQ_NOP   = 3'd7;

    // The sequencer holds this code when no command is in progress.
    localparam logic [2:0] CMD_IDLE = REQ_NOP;

    localparam logic [15:0] DELAY_TICKS_RESET = 16'd50;

    // Two-entry request queue between the front end and the sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] write_data;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       cmd_rejected;
    } res_t;

    // Classified request as it sits in the queue.
    typedef struct packed {
        logic       is_cmd;
        logic       is_tick;
        logic [2:0] cmd;
        logic [7:0] load_byte;
        logic       sda_in;
    } q_item_t;

endpackage

/* sv/i2cbe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine front end
// Accepts requests and classifies them into command, tick or no-op, and
// prepares the shift byte that a command loads.
// ----------------------------------------------------------------------------
module i2cbe_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  i2cbe_pkg::req_t    s_data,
    output logic               q_push,
    input  logic               q_full,
    output i2cbe_pkg::q_item_t q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.is_cmd    = (s_data.req_type <= i2cbe_pkg::REQ_CACK);
        q_item.is_tick   = (s_data.req_type == i2cbe_pkg::REQ_TICK);
        q_item.cmd       = s_data.req_type;
        q_item.sda_in    = s_data.sda_in;
        // Only a write command shifts out the supplied byte; others start from zero.
        q_item.load_byte = (s_data.req_type == i2cbe_pkg::REQ_WRITE) ? s_data.write_data
                                                                     : 8'h00;
    end

endmodule

/* sv/i2cbe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine request queue
// Two-entry first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cbe_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  i2cbe_pkg::q_item_t        push_item,
    output logic                      full,
    output logic                      not_empty,
    input  logic                      pop,
    output i2cbe_pkg::q_item_t        pop_item
);

    i2cbe_pkg::q_item_t                  entry_reg [i2cbe_pkg::QUEUE_DEPTH];
    logic [i2cbe_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [i2cbe_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [i2cbe_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                                do_push;
    logic                                do_pop;

    assign full      = (count_reg == i2cbe_pkg::QCNT_W'(i2cbe_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // The depth is a power of two, so the pointers wrap on their own.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/i2cbe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Carries out one queued request per cycle unless the output stalls: starts
// commands, counts ticks, steps the pin sequences and registers the result.
// ----------------------------------------------------------------------------
module i2cbe_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         delay_ticks,
    input  logic                q_not_empty,
    output logic                q_pop,
    input  i2cbe_pkg::q_item_t  q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cbe_pkg::res_t     m_data
);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  step;
        logic [3:0]  bit_idx;
        logic [15:0] ticks;
        logic [7:0]  shift;
        logic        scl;
        logic        sda;
        logic        sde;
        logic        ack;
        logic [7:0]  rx;
    } seq_t;

    typedef struct packed {
        seq_t st;
        logic fin;
    } step_res_t;

    localparam seq_t SEQ_RESET = '{
        cmd: i2cbe_pkg::CMD_IDLE, step: 3'd0, bit_idx: 4'd0, ticks: 16'd0,
        shift: 8'h00, scl: 1'b1, sda: 1'b1, sde: 1'b1, ack: 1'b0, rx: 8'h00
    };

    seq_t            seq_reg, seq_next;
    i2cbe_pkg::res_t m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;
    logic            done;
    logic            rejected;

    // Pin actions of the current step; fin marks the last step of a command.
    function automatic step_res_t apply_step(input seq_t cur, input logic line);
        step_res_t r;
        r.st  = cur;
        r.fin = 1'b0;
        case (cur.cmd)
            i2cbe_pkg::REQ_START: begin
                if (cur.step == 3'd0) r.st.sda = 1'b1;
                else if (cur.step == 3'd1) r.st.scl = 1'b1;
                else if (cur.step == 3'd2) r.st.sda = 1'b0;
                r.fin = (cur.step >= 3'd4);
            end
            i2cbe_pkg::REQ_STOP: begin
                if (cur.step == 3'd0) r.st.sda = 1'b0;
                else if (cur.step == 3'd1) r.st.scl = 1'b1;
                else if (cur.step == 3'd2) r.st.sda = 1'b1;
                r.fin = (cur.step >= 3'd4);
            end
            i2cbe_pkg::REQ_SACK: begin
                if (cur.step == 3'd0) r.st.scl = 1'b0;
                else if (cur.step == 3'd1) r.st.sda = 1'b0;
                else if (cur.step == 3'd2) r.st.scl = 1'b1;
                else begin
                    r.st.scl = 1'b0;
                    r.fin    = 1'b1;
                end
            end
            i2cbe_pkg::REQ_CACK: begin
                if (cur.step == 3'd0) begin
                    r.st.scl = 1'b0;
                    r.st.sda = 1'b1;
                end else if (cur.step == 3'd1) begin
                    r.st.sde = 1'b0;
                end else if (cur.step == 3'd2) begin
                    r.st.scl = 1'b1;
                    r.st.ack = !line;
                end else begin
                    r.st.scl = 1'b0;
                    r.st.sde = 1'b1;
                    r.fin    = 1'b1;
                end
            end
            i2cbe_pkg::REQ_WRITE: begin
                if (cur.step == 3'd0) r.st.scl = 1'b0;
                else if (cur.step == 3'd1) r.st.sda = cur.shift[7];
                else if (cur.step == 3'd2) r.st.scl = 1'b1;
                else r.fin = 1'b1;
            end
            i2cbe_pkg::REQ_READ: begin
                if (cur.step == 3'd0) begin
                    r.st.sda = 1'b1;
                end else if (cur.step == 3'd1) begin
                    r.st.sde = 1'b0;
                    r.st.scl = 1'b0;
                end else if (cur.step == 3'd3) begin
                    r.st.scl   = 1'b1;
                    r.st.shift = {cur.shift[6:0], line};
                end else if (cur.step >= 3'd4) begin
                    r.st.scl = 1'b0;
                    r.st.sde = 1'b1;
                    r.st.rx  = cur.shift;
                    r.fin    = 1'b1;
                end
            end
            default: begin
                r.fin = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Step that follows a finished delay unit; write and read loop per bit.
    function automatic seq_t next_step(input seq_t cur);
        seq_t n;
        n = cur;
        if (cur.cmd == i2cbe_pkg::REQ_WRITE && cur.step == 3'd2) begin
            n.shift   = {cur.shift[6:0], 1'b0};
            n.bit_idx = cur.bit_idx + 4'd1;
            n.step    = (n.bit_idx >= 4'd8) ? 3'd3 : 3'd0;
        end else if (cur.cmd == i2cbe_pkg::REQ_READ && cur.step == 3'd3) begin
            n.bit_idx = cur.bit_idx + 4'd1;
            n.step    = (n.bit_idx >= 4'd8) ? 3'd4 : 3'd1;
        end else begin
            n.step = cur.step + 3'd1;
        end
        return n;
    endfunction

    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin : seq_logic
        seq_t      t;
        step_res_t ar;
        logic      busy;
        busy     = (seq_reg.cmd != i2cbe_pkg::CMD_IDLE);
        t        = seq_reg;
        ar       = '{st: seq_reg, fin: 1'b0};
        done     = 1'b0;
        rejected = 1'b0;
        seq_next = seq_reg;
        if (q_pop) begin
            if (q_item.is_cmd) begin
                if (busy) begin
                    rejected = 1'b1;
                end else begin
                    t.cmd     = q_item.cmd;
                    t.step    = 3'd0;
                    t.bit_idx = 4'd0;
                    t.ticks   = 16'd0;
                    t.shift   = q_item.load_byte;
                    ar        = apply_step(t, q_item.sda_in);
                    seq_next  = ar.st;
                end
            end else if (q_item.is_tick && busy) begin
                t.ticks = seq_reg.ticks + 16'd1;
                // A delay of zero ends every unit on the first tick, as a delay of one.
                if (t.ticks >= delay_ticks) begin
                    t.ticks = 16'd0;
                    t       = next_step(t);
                    ar      = apply_step(t, q_item.sda_in);
                    t       = ar.st;
                    if (ar.fin) begin
                        t.cmd     = i2cbe_pkg::CMD_IDLE;
                        t.step    = 3'd0;
                        t.bit_idx = 4'd0;
                        done      = 1'b1;
                    end
                end
                seq_next = t;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (q_pop) begin
            m_valid_next                 = 1'b1;
            m_data_next.scl_level        = seq_next.scl;
            m_data_next.sda_level        = seq_next.sda;
            m_data_next.sda_drive_enable = seq_next.sde;
            m_data_next.busy_res         = (seq_next.cmd != i2cbe_pkg::CMD_IDLE);
            m_data_next.done_res         = done;
            m_data_next.read_byte        = seq_next.rx;
            m_data_next.ack_seen         = seq_next.ack;
            m_data_next.cmd_rejected     = rejected;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= SEQ_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/i2c_master_bit_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Each result passes through the request queue and then the output register.
// Throughput: one request per cycle while m_ready allows; the sequencer retires one
// queued request per cycle and the two-entry queue plus output register absorb stalls.
// Reset (aresetn low, synchronous): lines high and driven, no command active,
// delay_ticks back to 50, queue and output empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  i2cbe_pkg::req_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output i2cbe_pkg::res_t m_data
);

    logic [15:0]        delay_ticks_reg, delay_ticks_next;
    logic               q_push;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    i2cbe_pkg::q_item_t q_in_item;
    i2cbe_pkg::q_item_t q_out_item;

    assign delay_ticks_next = cfg_we ? cfg_wdata : delay_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= i2cbe_pkg::DELAY_TICKS_RESET;
        end else begin
            delay_ticks_reg <= delay_ticks_next;
        end
    end

    i2cbe_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_item  (q_in_item)
    );

    i2cbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_item  (q_out_item)
    );

    i2cbe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .delay_ticks (delay_ticks_reg),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_item      (q_out_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // A finished command leaves the engine idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done reported while still busy");

    // A rejected request never finishes a command.
    a_reject_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cmd_rejected |-> !m_data.done_res)
        else $error("rejected request reported as done");

    // SDA is only released in the middle of a command.
    a_release_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sda_drive_enable |-> m_data.busy_res)
        else $error("SDA released while idle");

    // The sequencer only retires a request that the queue holds, and only while the output is not stalled.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty && !(m_valid && !m_ready))
        else $error("queue popped while empty or output stalled");

endmodule

/* tb/tb_i2c_master_bit_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives start, stop, byte write, byte read and acknowledge commands, each
// followed by tick requests, at several delay settings. The block sits
// between a bursty sender and a stalling receiver. A line-level model of the
// sequencer predicts the pin levels, flags and assembled bytes for every
// request, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [15:0]     cfg_wdata = '0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    i2cbe_pkg::req_t s_data    = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    i2cbe_pkg::res_t m_data;

    i2c_master_bit_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Line-level model of the sequencer.
    logic [15:0] unit_ticks    = i2cbe_pkg::DELAY_TICKS_RESET;
    logic [2:0]  seq_cmd       = i2cbe_pkg::CMD_IDLE;
    logic [2:0]  seq_step      = '0;
    logic [3:0]  seq_bit       = '0;
    logic [15:0] seq_ticks     = '0;
    logic [7:0]  seq_shift     = '0;
    logic        scl_q         = 1'b1;
    logic        sda_q         = 1'b1;
    logic        sda_oe_q      = 1'b1;
    logic        ack_q         = 1'b0;
    logic [7:0]  rx_byte_q     = '0;

    i2cbe_pkg::res_t pin_reports_due[$];

    int  fail_count     = 0;
    int  reqs_sent      = 0;
    int  reports_seen   = 0;
    int  commands_done  = 0;
    int  commands_refused = 0;
    int  burst_left     = 0;
    bit  gaps_on        = 1'b1;
    bit  rx_free        = 1'b0;

    // Long receiver hold-off, started by a request from a test.
    logic hold_req   = 1'b0;
    logic holding    = 1'b0;
    int   hold_count = 0;

    // Receiver pattern state: alternating runs of ready and stalled cycles.
    logic rx_level = 1'b1;
    int   rx_run   = 0;

    function automatic bit sequencer_busy();
        return seq_cmd != i2cbe_pkg::CMD_IDLE;
    endfunction

    // Applies the pin actions of the current step; returns 1 when the command ends.
    function automatic logic apply_pin_step(input logic line);
        logic ends;
        ends = 1'b0;
        case (seq_cmd)
            i2cbe_pkg::REQ_START: begin
                if (seq_step == 3'd0) sda_q = 1'b1;
                else if (seq_step == 3'd1) scl_q = 1'b1;
                else if (seq_step == 3'd2) sda_q = 1'b0;
                ends = (seq_step >= 3'd4);
            end
            i2cbe_pkg::REQ_STOP: begin
                if (seq_step == 3'd0) sda_q = 1'b0;
                else if (seq_step == 3'd1) scl_q = 1'b1;
                else if (seq_step == 3'd2) sda_q = 1'b1;
                ends = (seq_step >= 3'd4);
            end
            i2cbe_pkg::REQ_SACK: begin
                case (seq_step)
                    3'd0: scl_q = 1'b0;
                    3'd1: sda_q = 1'b0;
                    3'd2: scl_q = 1'b1;
                    default: begin
                        scl_q = 1'b0;
                        ends  = 1'b1;
                    end
                endcase
            end
            i2cbe_pkg::REQ_CACK: begin
                case (seq_step)
                    3'd0: begin
                        scl_q = 1'b0;
                        sda_q = 1'b1;
                    end
                    3'd1: sda_oe_q = 1'b0;
                    3'd2: begin
                        scl_q = 1'b1;
                        ack_q = ~line;
                    end
                    default: begin
                        scl_q    = 1'b0;
                        sda_oe_q = 1'b1;
                        ends     = 1'b1;
                    end
                endcase
            end
            i2cbe_pkg::REQ_WRITE: begin
                case (seq_step)
                    3'd0: scl_q = 1'b0;
                    3'd1: sda_q = seq_shift[7];
                    3'd2: scl_q = 1'b1;
                    default: ends = 1'b1;
                endcase
            end
            i2cbe_pkg::REQ_READ: begin
                if (seq_step == 3'd0) begin
                    sda_q = 1'b1;
                end else if (seq_step == 3'd1) begin
                    sda_oe_q = 1'b0;
                    scl_q    = 1'b0;
                end else if (seq_step == 3'd3) begin
                    scl_q     = 1'b1;
                    seq_shift = {seq_shift[6:0], line};
                end else if (seq_step >= 3'd4) begin
                    scl_q     = 1'b0;
                    sda_oe_q  = 1'b1;
                    rx_byte_q = seq_shift;
                    ends      = 1'b1;
                end
            end
            default: ends = 1'b1;
        endcase
        return ends;
    endfunction

    function automatic void next_pin_step();
        if (seq_cmd == i2cbe_pkg::REQ_WRITE && seq_step == 3'd2) begin
            seq_shift = {seq_shift[6:0], 1'b0};
            seq_bit   = seq_bit + 4'd1;
            seq_step  = (seq_bit >= 4'd8) ? 3'd3 : 3'd0;
        end else if (seq_cmd == i2cbe_pkg::REQ_READ && seq_step == 3'd3) begin
            seq_bit  = seq_bit + 4'd1;
            seq_step = (seq_bit >= 4'd8) ? 3'd4 : 3'd1;
        end else begin
            seq_step = seq_step + 3'd1;
        end
    endfunction

    function automatic i2cbe_pkg::res_t advance_sequencer(input i2cbe_pkg::req_t r);
        i2cbe_pkg::res_t rep;
        logic finished;
        logic refused;
        logic was_busy;
        finished = 1'b0;
        refused  = 1'b0;
        was_busy = sequencer_busy();
        if (r.req_type <= i2cbe_pkg::REQ_CACK) begin
            if (was_busy) begin
                refused = 1'b1;
            end else begin
                seq_cmd   = r.req_type;
                seq_step  = '0;
                seq_bit   = '0;
                seq_ticks = '0;
                seq_shift = (r.req_type == i2cbe_pkg::REQ_WRITE) ? r.write_data : 8'h00;
                void'(apply_pin_step(r.sda_in));
            end
        end else if (r.req_type == i2cbe_pkg::REQ_TICK && was_busy) begin
            seq_ticks = seq_ticks + 16'd1;
            if (seq_ticks >= unit_ticks) begin
                seq_ticks = '0;
                next_pin_step();
                if (apply_pin_step(r.sda_in)) begin
                    seq_cmd  = i2cbe_pkg::CMD_IDLE;
                    seq_step = '0;
                    seq_bit  = '0;
                    finished = 1'b1;
                end
            end
        end
        rep.scl_level        = scl_q;
        rep.sda_level        = sda_q;
        rep.sda_drive_enable = sda_oe_q;
        rep.busy_res         = sequencer_busy();
        rep.done_res         = finished;
        rep.read_byte        = rx_byte_q;
        rep.ack_seen         = ack_q;
        rep.cmd_rejected     = refused;
        return rep;
    endfunction

    // Receiver: run-length stall pattern, overridden by the long hold-off.
    always @(posedge aclk) begin
        if (!aresetn || holding) begin
            m_ready <= 1'b0;
        end else if (rx_free) begin
            m_ready <= 1'b1;
        end else if (rx_run != 0) begin
            rx_run  <= rx_run - 1;
            m_ready <= rx_level;
        end else begin
            rx_level <= ~rx_level;
            rx_run   <= rx_level ? $urandom_range(1, 6) : $urandom_range(1, 40);
            m_ready  <= ~rx_level;
        end
    end

    always @(posedge aclk) begin
        if (holding) begin
            if (hold_count == 0) holding <= 1'b0;
            else hold_count <= hold_count - 1;
        end else if (hold_req) begin
            holding    <= 1'b1;
            hold_count <= 300;
            hold_req   <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        i2cbe_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pin_reports_due.size() == 0) begin
                $error("result arrived with nothing outstanding: %p", m_data);
                fail_count++;
            end else begin
                want = pin_reports_due.pop_front();
                reports_seen++;
                if (want.done_res) commands_done++;
                if (want.cmd_rejected) commands_refused++;
                compare_field("scl_level", 8'(want.scl_level), 8'(m_data.scl_level));
                compare_field("sda_level", 8'(want.sda_level), 8'(m_data.sda_level));
                compare_field("sda_drive_enable", 8'(want.sda_drive_enable),
                              8'(m_data.sda_drive_enable));
                compare_field("busy_res", 8'(want.busy_res), 8'(m_data.busy_res));
                compare_field("done_res", 8'(want.done_res), 8'(m_data.done_res));
                compare_field("read_byte", want.read_byte, m_data.read_byte);
                compare_field("ack_seen", 8'(want.ack_seen), 8'(m_data.ack_seen));
                compare_field("cmd_rejected", 8'(want.cmd_rejected),
                              8'(m_data.cmd_rejected));
            end
        end
    end

    // Offers one request and returns once it is taken; the sender idles in bursts.
    task automatic send_req(input logic [2:0] kind, input logic [7:0] data,
                            input logic line);
        i2cbe_pkg::req_t r;
        r.req_type   = kind;
        r.write_data = data;
        r.sda_in     = line;
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        pin_reports_due.push_back(advance_sequencer(r));
        reqs_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pin_reports_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_delay_ticks(input logic [15:0] value);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        unit_ticks  = value;
    endtask

    // Ticks until the command ends; the line level at each read sample comes
    // from the pattern, most significant bit first.
    task automatic finish_command(input logic [7:0] pattern);
        while (sequencer_busy())
            send_req(i2cbe_pkg::REQ_TICK, 8'h00, pattern[~seq_bit[2:0]]);
    endtask

    task automatic run_command(input logic [2:0] kind, input logic [7:0] data,
                               input logic [7:0] pattern);
        send_req(kind, data, pattern[7]);
        finish_command(pattern);
    endtask

    task automatic test_default_delay();
        // No register write yet, so each delay unit lasts the reset value.
        run_command(i2cbe_pkg::REQ_CACK, 8'h00, 8'h00);
    endtask

    task automatic test_directed_sequences();
        set_delay_ticks(16'd1);
        send_req(i2cbe_pkg::REQ_TICK, 8'hFF, 1'b1);
        send_req(i2cbe_pkg::REQ_NOP, 8'hFF, 1'b1);
        send_req(i2cbe_pkg::REQ_NOP, 8'h00, 1'b0);
        run_command(i2cbe_pkg::REQ_START, 8'h00, 8'h00);
        send_req(i2cbe_pkg::REQ_WRITE, 8'hFF, 1'b0);
        send_req(i2cbe_pkg::REQ_WRITE, 8'h00, 1'b1);
        send_req(i2cbe_pkg::REQ_NOP, 8'h00, 1'b0);
        finish_command(8'h00);
        run_command(i2cbe_pkg::REQ_WRITE, 8'h00, 8'hFF);
        run_command(i2cbe_pkg::REQ_WRITE, 8'hA5, 8'h00);
        run_command(i2cbe_pkg::REQ_READ, 8'h00, 8'hA5);
        run_command(i2cbe_pkg::REQ_READ, 8'hFF, 8'h5A);
        run_command(i2cbe_pkg::REQ_SACK, 8'h00, 8'h00);
        run_command(i2cbe_pkg::REQ_CACK, 8'h00, 8'h00);
        run_command(i2cbe_pkg::REQ_CACK, 8'h00, 8'hFF);
        run_command(i2cbe_pkg::REQ_STOP, 8'h00, 8'h00);
        // A zero setting must behave like one tick per unit.
        set_delay_ticks(16'd0);
        run_command(i2cbe_pkg::REQ_SACK, 8'h00, 8'h00);
        run_command(i2cbe_pkg::REQ_READ, 8'h00, 8'hC3);
        run_command(i2cbe_pkg::REQ_STOP, 8'h00, 8'h00);
    endtask

    task automatic test_max_delay();
        set_delay_ticks(16'hFFFF);
        gaps_on = 1'b0;
        rx_free = 1'b1;
        send_req(i2cbe_pkg::REQ_START, 8'h00, 1'b0);
        // The longest unit never ends within these ticks; a shorter setting
        // then ends the unit on the very next tick.
        repeat (64) send_req(i2cbe_pkg::REQ_TICK, 8'h00, 1'b0);
        set_delay_ticks(16'd1);
        finish_command(8'h00);
        gaps_on = 1'b1;
        rx_free = 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        int issued;
        int pick;
        issued = 0;
        while (issued < count) begin
            if ($urandom_range(0, 7) == 0)
                send_req(3'($urandom_range(i2cbe_pkg::REQ_TICK, i2cbe_pkg::REQ_NOP)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_req(3'($urandom_range(i2cbe_pkg::REQ_START, i2cbe_pkg::REQ_CACK)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            issued++;
            while (sequencer_busy()) begin
                pick = $urandom_range(0, 31);
                if (pick == 0)
                    send_req(3'($urandom_range(i2cbe_pkg::REQ_START, i2cbe_pkg::REQ_CACK)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else if (pick == 1)
                    send_req(i2cbe_pkg::REQ_NOP, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                else
                    send_req(i2cbe_pkg::REQ_TICK, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                issued++;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] phase_delay;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: phase_delay = 16'd1;
                1: phase_delay = 16'd2;
                2: phase_delay = 16'd0;
                3: phase_delay = 16'd3;
                default: phase_delay = 16'($urandom_range(4, 6));
            endcase
            set_delay_ticks(phase_delay);
            gaps_on = ($urandom_range(0, 3) != 0);
            rx_free = ($urandom_range(0, 3) == 0);
            run_random_phase(170);
        end
        gaps_on = 1'b1;
        rx_free = 1'b0;
    endtask

    task automatic test_output_hold_off();
        set_delay_ticks(16'd1);
        gaps_on  = 1'b0;
        hold_req <= 1'b1;
        run_command(i2cbe_pkg::REQ_WRITE, 8'($urandom_range(0, 255)), 8'h00);
        run_command(i2cbe_pkg::REQ_READ, 8'h00, 8'($urandom_range(0, 255)));
        gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_delay_ticks(16'd2);
        send_req(i2cbe_pkg::REQ_READ, 8'h00, 1'b0);
        repeat (9) send_req(i2cbe_pkg::REQ_TICK, 8'h00, 1'($urandom_range(0, 1)));
        // Let every outstanding result drain while the command is half done.
        wait_all_results();
        finish_command(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_delay();
        test_directed_sequences();
        test_max_delay();
        test_random_traffic();
        test_output_hold_off();
        test_sender_pause();
        wait_all_results();
        repeat (20) @(posedge aclk);
        $display("Sent %0d requests and checked %0d results over delay settings 0 to 65535.",
                 reqs_sent, reports_seen);
        $display("Commands finished: %0d, commands refused while busy: %0d.",
                 commands_done, commands_refused);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
